### design/mgtrs_pkg.sv
// Shared types and constants for the guarded UART transmit ring scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package mgtrs_pkg;

    localparam int BUF_DEPTH_DEF = 512;
    localparam int MSG_SLOTS_DEF = 16;

    localparam int MSG_LEN_W  = 9;
    localparam int BYTE_W     = 8;
    localparam int WM_W       = 9;
    localparam int GT_W       = 10;
    localparam int PEND_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [2:0] {
        OP_BEGIN = 3'd0,
        OP_BYTE  = 3'd1,
        OP_TICK  = 3'd2,
        OP_CHUNK = 3'd3,
        OP_READ  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TELEM   = 2'd1,
        KIND_MODBUS  = 2'd2,
        KIND_REFUSED = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_WATERMARK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 1'b1;

    localparam logic [WM_W-1:0]   WM_RESET = 9'd384;
    localparam logic [GT_W-1:0]   GT_RESET = 10'd4;
    localparam logic [PEND_W-1:0] PEND_MAX = 5'd31;

endpackage
`default_nettype wire

### design/modbus_guarded_tx_ring_scheduler.sv
// Transmit scheduler for one shared UART: byte ring, descriptor queue and T3.5 guard.
// Depends on mgtrs_pkg, mgtrs_ring and mgtrs_desc.
//
// One request is taken when start is high and busy is low; its result shows on the o_
// ports for one cycle with o_valid, and must be taken then. Begin, byte, tick, read and
// unused-opcode requests go from idle through one execute state back to idle, as does a
// chunk-sent request while no chunk is running. A chunk-sent request that ends a running
// chunk passes through a wait and a check state for each descriptor it retires, and
// once more to finish, since each descriptor is a read-modify step through the
// registered descriptor memory. BUF_DEPTH and MSG_SLOTS must be powers of two. The ring
// and descriptor memories need no clearing.
`default_nettype none
module modbus_guarded_tx_ring_scheduler
    import mgtrs_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int MSG_SLOTS = MSG_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [2:0]            i_opcode,
    input  wire logic [MSG_LEN_W-1:0]  i_msg_len,
    input  wire logic                  i_is_modbus,
    input  wire logic [BYTE_W-1:0]     i_data_byte,
    input  wire logic [MSG_LEN_W-1:0]  i_read_index,
    output logic                       o_valid,
    output logic                       o_rejected,
    output logic                       o_dma_start,
    output logic [MSG_LEN_W-1:0]       o_dma_offset,
    output logic [MSG_LEN_W-1:0]       o_dma_length,
    output logic [BYTE_W-1:0]          o_read_data,
    output logic [MSG_LEN_W-1:0]       o_tx_used,
    output logic                       o_guard_active
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int DW = $clog2(MSG_SLOTS);
    localparam int CW = (AW > MSG_LEN_W) ? AW : MSG_LEN_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_RWAIT = 4'b0100,
        S_RCHK  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // request payload
    t_opcode              r_op;
    logic [MSG_LEN_W-1:0] r_mlen;
    logic                 r_modbus;
    logic [BYTE_W-1:0]    r_byte;

    logic [WM_W-1:0] r_wm;
    logic [GT_W-1:0] r_gt;

    logic [AW-1:0]        r_head, n_head, r_tail, n_tail, r_stage, n_stage;
    logic [AW-1:0]        r_chunk, n_chunk, r_open_len, n_open_len, r_remain, n_remain;
    logic                 r_dma_busy, n_dma_busy;
    logic [DW-1:0]        r_wp, n_wp, r_rp, n_rp;
    logic [DW:0]          r_nret, n_nret;
    logic [PEND_W-1:0]    r_mb_pend, n_mb_pend;
    logic                 r_guard_on, n_guard_on;
    logic [GT_W-1:0]      r_guard_el, n_guard_el;
    logic [MSG_LEN_W-1:0] r_btc, n_btc;
    t_kind                r_kind, n_kind;

    logic                 n_valid, n_rej, n_dstart;
    logic [MSG_LEN_W-1:0] n_doff, n_dlen;
    logic [BYTE_W-1:0]    n_rdata;

    logic              ring_we;
    logic [AW-1:0]     ring_waddr;
    logic [BYTE_W-1:0] ring_wdata, ring_rdata;
    logic              desc_we;
    logic [DW-1:0]     desc_waddr;
    logic [AW-1:0]     desc_wlen, desc_rlen;
    logic              desc_wmb, desc_rmb;

    logic [AW-1:0]     used, freeb;
    logic [DW-1:0]     cnt, k_cnt;
    logic              grun, rej, cmt, cmt_mb, k_en, k_front, k_grun, fin;
    logic [BYTE_W-1:0] rd_out;

    mgtrs_ring #(.BUF_DEPTH(BUF_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (AW'(i_read_index)),
        .o_rdata (ring_rdata)
    );

    mgtrs_desc #(.MSG_SLOTS(MSG_SLOTS), .LEN_W(AW)) u_desc (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wlen  (desc_wlen),
        .i_wmb   (desc_wmb),
        .i_raddr (r_rp),
        .o_rlen  (desc_rlen),
        .o_rmb   (desc_rmb)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_tx_used      = MSG_LEN_W'(r_head - r_tail);
    assign o_guard_active = r_guard_on && (r_guard_el < r_gt);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_stage    = r_stage;
        n_chunk    = r_chunk;
        n_open_len = r_open_len;
        n_remain   = r_remain;
        n_dma_busy = r_dma_busy;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_nret     = r_nret;
        n_mb_pend  = r_mb_pend;
        n_guard_on = r_guard_on;
        n_guard_el = r_guard_el;
        n_btc      = r_btc;
        n_kind     = r_kind;

        ring_we    = 1'b0;
        ring_waddr = r_stage;
        ring_wdata = r_byte;
        desc_we    = 1'b0;
        desc_waddr = r_wp;
        desc_wlen  = r_open_len;
        desc_wmb   = 1'b0;

        used    = r_head - r_tail;
        freeb   = AW'(BUF_DEPTH - 1) - used;
        cnt     = r_wp - r_rp;
        grun    = r_guard_on && (r_guard_el < r_gt);
        rej     = 1'b0;
        cmt     = 1'b0;
        cmt_mb  = 1'b0;
        k_en    = 1'b0;
        k_front = desc_rmb;
        fin     = 1'b0;
        rd_out  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                fin     = 1'b1;
                case (r_op)
                    OP_BEGIN: begin
                        n_kind = KIND_NONE;
                        n_btc  = '0;
                        if (!r_modbus && ((CW'(used) >= CW'(r_wm)) || (r_mb_pend != '0)
                                          || grun)) begin
                            rej = 1'b1;
                        end
                        if ((CW'(r_mlen) > CW'(freeb)) || (cnt == DW'(MSG_SLOTS - 1))) begin
                            rej = 1'b1;
                        end
                        if (rej) begin
                            if (r_mlen != '0) begin
                                n_kind = KIND_REFUSED;
                                n_btc  = r_mlen;
                            end
                        end else begin
                            n_kind     = r_modbus ? KIND_MODBUS : KIND_TELEM;
                            n_btc      = r_mlen;
                            n_open_len = AW'(r_mlen);
                            n_stage    = r_head;
                            if (r_mlen == '0) begin
                                cmt    = 1'b1;
                                cmt_mb = r_modbus;
                            end
                        end
                    end
                    OP_BYTE: begin
                        if (r_kind == KIND_REFUSED) begin
                            if (r_btc != '0) begin
                                n_btc = r_btc - 1'b1;
                            end
                            if (n_btc == '0) begin
                                n_kind = KIND_NONE;
                            end
                        end else if (r_kind != KIND_NONE && r_btc != '0) begin
                            ring_we = 1'b1;
                            n_stage = r_stage + 1'b1;
                            n_btc   = r_btc - 1'b1;
                            if (n_btc == '0) begin
                                cmt    = 1'b1;
                                cmt_mb = (r_kind == KIND_MODBUS);
                            end
                        end
                    end
                    OP_TICK: begin
                        if (grun) begin
                            n_guard_el = r_guard_el + 1'b1;
                        end
                        k_en = 1'b1;
                    end
                    OP_CHUNK: begin
                        if (r_dma_busy) begin
                            n_tail     = r_tail + r_chunk;
                            n_dma_busy = 1'b0;
                            n_remain   = r_chunk;
                            n_nret     = '0;
                            n_state    = S_RWAIT;
                            fin        = 1'b0;
                        end
                    end
                    OP_READ: begin
                        rd_out = ring_rdata;
                    end
                    default: ;
                endcase
            end
            S_RWAIT: begin
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (r_remain == '0 || cnt == '0 || r_nret == (DW+1)'(MSG_SLOTS)) begin
                    k_en    = 1'b1;
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else if (r_remain >= desc_rlen) begin
                    n_remain = r_remain - desc_rlen;
                    if (desc_rmb) begin
                        if (r_mb_pend != '0) begin
                            n_mb_pend = r_mb_pend - 1'b1;
                        end
                        n_guard_on = 1'b1;
                        n_guard_el = '0;
                    end
                    n_rp    = r_rp + 1'b1;
                    n_nret  = r_nret + 1'b1;
                    n_state = S_RWAIT;
                end else begin
                    // chunk ends inside this message: shorten it in place
                    desc_we    = 1'b1;
                    desc_waddr = r_rp;
                    desc_wlen  = desc_rlen - r_remain;
                    desc_wmb   = desc_rmb;
                    n_remain   = '0;
                    k_en       = 1'b1;
                    fin        = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmt) begin
            n_head     = n_stage;
            desc_we    = 1'b1;
            desc_waddr = r_wp;
            desc_wlen  = n_open_len;
            desc_wmb   = cmt_mb;
            if (cmt_mb && r_mb_pend != PEND_MAX) begin
                n_mb_pend = r_mb_pend + 1'b1;
            end
            n_wp   = r_wp + 1'b1;
            n_kind = KIND_NONE;
            n_btc  = '0;
            k_en   = 1'b1;
            // empty queue: the new descriptor is the front, bypass the memory
            k_front = (cnt == '0) ? cmt_mb : desc_rmb;
        end

        k_cnt    = n_wp - n_rp;
        k_grun   = n_guard_on && (n_guard_el < r_gt);
        n_dstart = 1'b0;
        n_doff   = '0;
        n_dlen   = '0;
        if (k_en && !n_dma_busy && (n_head != n_tail)
            && !(k_grun && k_cnt != '0 && !k_front)) begin
            n_guard_on = k_grun;
            n_chunk    = (n_tail < n_head) ? (n_head - n_tail) : (AW'(0) - n_tail);
            n_dma_busy = 1'b1;
            n_dstart   = 1'b1;
            n_doff     = MSG_LEN_W'(n_tail);
            n_dlen     = MSG_LEN_W'(n_chunk);
        end

        n_valid = fin;
        n_rej   = rej;
        n_rdata = rd_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wm       <= WM_RESET;
            r_gt       <= GT_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_stage    <= '0;
            r_chunk    <= '0;
            r_open_len <= '0;
            r_remain   <= '0;
            r_dma_busy <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_nret     <= '0;
            r_mb_pend  <= '0;
            r_guard_on <= 1'b0;
            r_guard_el <= '0;
            r_btc      <= '0;
            r_kind     <= KIND_NONE;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_stage    <= n_stage;
            r_chunk    <= n_chunk;
            r_open_len <= n_open_len;
            r_remain   <= n_remain;
            r_dma_busy <= n_dma_busy;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_nret     <= n_nret;
            r_mb_pend  <= n_mb_pend;
            r_guard_on <= n_guard_on;
            r_guard_el <= n_guard_el;
            r_btc      <= n_btc;
            r_kind     <= n_kind;
            o_valid    <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WATERMARK: r_wm <= i_cfg_wdata[WM_W-1:0];
                    CFG_GUARD:     r_gt <= i_cfg_wdata[GT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op     <= t_opcode'(i_opcode);
            r_mlen   <= i_msg_len;
            r_modbus <= i_is_modbus;
            r_byte   <= i_data_byte;
        end
        o_rejected   <= n_rej;
        o_dma_start  <= n_dstart;
        o_dma_offset <= n_doff;
        o_dma_length <= n_dlen;
        o_read_data  <= n_rdata;
    end

    // results never come back to back: every request passes through a working state after idle
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on consecutive cycles");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_EXEC || $past(r_state) == S_RCHK))
        else $error("result strobe without a finishing step");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dma_start) |-> r_dma_busy)
        else $error("chunk reported started but DMA not marked busy");

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == KIND_NONE) == (r_btc == '0))
        else $error("open message state and byte count disagree");

    a_accept_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

endmodule
`default_nettype wire

### design/mgtrs_ring.sv
// Byte ring storage: one write port, one read port, registered read data.
// Depends on mgtrs_pkg for the default depth and byte width.
`default_nettype none
module mgtrs_ring
    import mgtrs_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/mgtrs_desc.sv
// Message descriptor store: length and Modbus flag per slot, registered read.
// Depends on mgtrs_pkg for the default slot count.
`default_nettype none
module mgtrs_desc
    import mgtrs_pkg::*;
#(
    parameter int MSG_SLOTS = MSG_SLOTS_DEF,
    parameter int LEN_W     = $clog2(BUF_DEPTH_DEF),
    localparam int DW = $clog2(MSG_SLOTS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [DW-1:0]    i_waddr,
    input  wire logic [LEN_W-1:0] i_wlen,
    input  wire logic             i_wmb,
    input  wire logic [DW-1:0]    i_raddr,
    output logic      [LEN_W-1:0] o_rlen,
    output logic                  o_rmb
);

    logic [LEN_W:0] r_mem [MSG_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wmb, i_wlen};
        end
        {o_rmb, o_rlen} <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
